>>> rtl/core/aimi_pkg.sv
// Shared types and constants for the ignition advance map interpolator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package aimi_pkg;

    // Default table geometry.
    localparam int SPEED_BINS_DEF = 16;
    localparam int LOAD_ROWS_DEF  = 16;

    // Item operation codes.
    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_WR_SPEED = 2'd1;
    localparam logic [1:0] OP_WR_LOAD  = 2'd2;
    localparam logic [1:0] OP_WR_CELL  = 2'd3;

    // Fixed-point widths. Row results stay below 2^24 in magnitude.
    localparam int FRAC_W    = 16;
    localparam int BP_W      = 16;
    localparam int CELL_W    = 8;
    localparam int DX_W      = 17;
    localparam int Y_W       = 25;
    localparam int DY_W      = 26;
    localparam int NUM_W     = DY_W + FRAC_W;
    localparam int DEN_W     = 16;
    localparam int P_W       = NUM_W + DX_W;
    localparam int ADV_W     = 45;
    localparam int CMD_DEPTH = 4;

    typedef struct packed {
        logic [1:0]               operation;
        logic [15:0]              engine_speed;
        logic [15:0]              engine_load;
        logic [3:0]               row_index;
        logic [3:0]               column_index;
        logic [15:0]              breakpoint_value;
        logic signed [CELL_W-1:0] cell_value;
    } t_in_item;

    typedef struct packed {
        logic signed [CELL_W-1:0] advance_degrees;
        logic [3:0]               speed_bin;
        logic [3:0]               load_bin;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DX_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> rtl/core/aimi_cmd_fifo.sv
// Short command queue between the front end and the lookup engine.
// Depends on aimi_pkg for the item type and the queue depth.
`default_nettype none
module aimi_cmd_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire aimi_pkg::t_in_item i_wr_item,
    output logic                   o_full,
    input  wire logic              i_rd,
    output logic                   o_empty,
    output aimi_pkg::t_in_item     o_rd_item
);
    localparam int PTR_W = $clog2(aimi_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(aimi_pkg::CMD_DEPTH + 1);

    aimi_pkg::t_in_item r_mem [aimi_pkg::CMD_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full    = (r_cnt == CNT_W'(aimi_pkg::CMD_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rd_item = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/aimi_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// Depends on aimi_pkg for widths and the request and response types.
`default_nettype none
module aimi_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aimi_pkg::t_div_req i_req,
    output aimi_pkg::t_div_rsp     o_rsp
);
    localparam int NUM_W = aimi_pkg::NUM_W;
    localparam int DEN_W = aimi_pkg::DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    // One restoring step.
    always_comb begin
        trial = {r_rem, r_dvd[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -signed'(r_dvd) : signed'(r_dvd);

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands in magnitude form; the dividend register collects the quotient.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);
            r_den <= i_req.den[aimi_pkg::DX_W-1] ? DEN_W'(-i_req.den) : DEN_W'(i_req.den);
            r_neg <= i_req.num[NUM_W-1] ^ i_req.den[aimi_pkg::DX_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[NUM_W-2:0], fits};
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/aimi_engine.sv
// Back end: executes store writes and lookups (bin search, table reads and
// three interpolations) in order. Depends on aimi_pkg and aimi_divider.
`default_nettype none
module aimi_engine #(
    parameter int SPEED_BINS = aimi_pkg::SPEED_BINS_DEF,
    parameter int LOAD_ROWS  = aimi_pkg::LOAD_ROWS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_empty,
    input  wire aimi_pkg::t_in_item i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_res_empty,
    input  wire logic               i_res_pop,
    output aimi_pkg::t_out_item     o_res
);
    localparam int SB_W  = $clog2(SPEED_BINS);
    localparam int LB_W  = $clog2(LOAD_ROWS);
    localparam int BIN_W = (SB_W > LB_W) ? SB_W : LB_W;
    localparam int TA_W  = $clog2(SPEED_BINS * LOAD_ROWS);
    localparam int Y_W   = aimi_pkg::Y_W;
    localparam int DX_W  = aimi_pkg::DX_W;
    localparam int NUM_W = aimi_pkg::NUM_W;
    localparam int P_W   = aimi_pkg::P_W;
    localparam int ADV_W = aimi_pkg::ADV_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_NXT  = 4'd4;
    localparam logic [3:0] S_TRD  = 4'd5;
    localparam logic [3:0] S_IP   = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ADD  = 4'd9;
    localparam logic [3:0] S_STO  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // Stores.
    logic [15:0]        r_spd_mem [SPEED_BINS];
    logic [15:0]        r_lod_mem [LOAD_ROWS];
    logic signed [7:0]  r_tbl_mem [SPEED_BINS * LOAD_ROWS];
    logic [15:0]        r_spd_q;
    logic [15:0]        r_lod_q;
    logic signed [7:0]  r_tbl_q;

    // Control state.
    logic [3:0]         r_state;
    logic               r_axis;
    logic [BIN_W-1:0]   r_bin;
    logic [2:0]         r_tcnt;
    logic [1:0]         r_ip;
    logic               r_out_valid;

    // Lookup payload.
    logic [15:0]        r_speed;
    logic [15:0]        r_load;
    logic [SB_W-1:0]    r_sb;
    logic [SB_W-1:0]    r_sn;
    logic [LB_W-1:0]    r_lb;
    logic [LB_W-1:0]    r_ln;
    logic [15:0]        r_sx1;
    logic [15:0]        r_sx2;
    logic [15:0]        r_lx1;
    logic [15:0]        r_lx2;
    logic signed [7:0]  r_a [4];
    logic signed [Y_W-1:0]   r_r0;
    logic signed [Y_W-1:0]   r_r1;
    logic signed [Y_W-1:0]   r_y1;
    logic signed [DX_W-1:0]  r_dxx;
    logic signed [NUM_W-1:0] r_quot;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ADV_W-1:0] r_res;
    aimi_pkg::t_out_item     r_out;

    // Combinational helpers.
    logic                    wr_spd;
    logic                    wr_lod;
    logic                    wr_tbl;
    logic [TA_W-1:0]         wr_addr;
    logic [TA_W-1:0]         rd_addr;
    logic [SB_W-1:0]         t_col;
    logic [LB_W-1:0]         t_row;
    logic [15:0]             scan_d;
    logic [15:0]             scan_x;
    logic [BIN_W-1:0]        scan_top;
    logic                    scan_cont;
    logic [BIN_W-1:0]        scan_next;
    logic signed [Y_W-1:0]   ip_y1;
    logic signed [Y_W-1:0]   ip_y2;
    logic [15:0]             ip_x;
    logic [15:0]             ip_x1;
    logic [15:0]             ip_x2;
    logic signed [DX_W-1:0]  ip_dx;
    logic signed [DX_W-1:0]  ip_dxx;
    logic signed [aimi_pkg::DY_W-1:0] ip_dy;
    logic signed [P_W-1:0]   mul;
    logic signed [7:0]       sat;
    aimi_pkg::t_div_req      div_req;
    aimi_pkg::t_div_rsp      div_rsp;

    assign o_cmd_pop   = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_empty = !r_out_valid;
    assign o_res       = r_out;

    // Store writes, taken from the head of the queue.
    always_comb begin
        wr_spd  = o_cmd_pop && (i_cmd.operation == aimi_pkg::OP_WR_SPEED);
        wr_lod  = o_cmd_pop && (i_cmd.operation == aimi_pkg::OP_WR_LOAD);
        wr_tbl  = o_cmd_pop && (i_cmd.operation == aimi_pkg::OP_WR_CELL);
        wr_addr = TA_W'(32'(i_cmd.row_index) * SPEED_BINS + 32'(i_cmd.column_index));
        t_row   = r_tcnt[1] ? r_ln : r_lb;
        t_col   = r_tcnt[0] ? r_sn : r_sb;
        rd_addr = TA_W'(32'(t_row) * SPEED_BINS + 32'(t_col));
    end

    // Breakpoint and table memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_spd) begin
            r_spd_mem[SB_W'(i_cmd.row_index)] <= i_cmd.breakpoint_value;
        end
        r_spd_q <= r_spd_mem[SB_W'(r_bin)];
    end

    always_ff @(posedge i_clk) begin
        if (wr_lod) begin
            r_lod_mem[LB_W'(i_cmd.row_index)] <= i_cmd.breakpoint_value;
        end
        r_lod_q <= r_lod_mem[LB_W'(r_bin)];
    end

    always_ff @(posedge i_clk) begin
        if (wr_tbl) begin
            r_tbl_mem[wr_addr] <= i_cmd.cell_value;
        end
        r_tbl_q <= r_tbl_mem[rd_addr];
    end

    // Downward bin scan for the current axis.
    always_comb begin
        scan_d    = r_axis ? r_lod_q : r_spd_q;
        scan_x    = r_axis ? r_load : r_speed;
        scan_top  = r_axis ? BIN_W'(LOAD_ROWS - 1) : BIN_W'(SPEED_BINS - 1);
        scan_cont = (r_bin != '0) && (scan_x < scan_d);
        if ((r_bin == '0) && (scan_x < scan_d)) begin
            scan_next = '0;
        end else if (r_bin < scan_top) begin
            scan_next = r_bin + 1'b1;
        end else begin
            scan_next = r_bin;
        end
    end

    // Operands of the current interpolation.
    always_comb begin
        unique case (r_ip)
            2'd0: begin
                ip_y1 = Y_W'(r_a[0]);
                ip_y2 = Y_W'(r_a[1]);
                ip_x  = r_speed;
                ip_x1 = r_sx1;
                ip_x2 = r_sx2;
            end
            2'd1: begin
                ip_y1 = Y_W'(r_a[2]);
                ip_y2 = Y_W'(r_a[3]);
                ip_x  = r_speed;
                ip_x1 = r_sx1;
                ip_x2 = r_sx2;
            end
            default: begin
                ip_y1 = r_r0;
                ip_y2 = r_r1;
                ip_x  = r_load;
                ip_x1 = r_lx1;
                ip_x2 = r_lx2;
            end
        endcase
        ip_dx  = signed'({1'b0, ip_x2}) - signed'({1'b0, ip_x1});
        ip_dxx = signed'({1'b0, ip_x}) - signed'({1'b0, ip_x1});
        ip_dy  = aimi_pkg::DY_W'(ip_y2) - aimi_pkg::DY_W'(ip_y1);
        mul    = r_quot * r_dxx;
        if (r_res > ADV_W'(127)) begin
            sat = 8'sd127;
        end else if (r_res < -ADV_W'(128)) begin
            sat = -8'sd128;
        end else begin
            sat = r_res[7:0];
        end
    end

    // The slope divide goes to the engine's own divider.
    always_comb begin
        div_req.start = (r_state == S_IP) && (ip_dx != '0);
        div_req.num   = NUM_W'(ip_dy) <<< aimi_pkg::FRAC_W;
        div_req.den   = ip_dx;
    end

    aimi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_bin       <= '0;
            r_tcnt      <= '0;
            r_ip        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_res_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && (i_cmd.operation == aimi_pkg::OP_LOOKUP)) begin
                        r_axis  <= 1'b0;
                        r_bin   <= BIN_W'(SPEED_BINS - 1);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (scan_cont) begin
                        r_bin   <= r_bin - 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_bin   <= scan_next;
                        r_state <= S_RD2;
                    end
                end
                S_RD2: begin
                    r_state <= S_NXT;
                end
                S_NXT: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_bin   <= BIN_W'(LOAD_ROWS - 1);
                        r_state <= S_RD;
                    end else begin
                        r_tcnt  <= '0;
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    r_tcnt <= r_tcnt + 1'b1;
                    if (r_tcnt == 3'd4) begin
                        r_ip    <= 2'd0;
                        r_state <= S_IP;
                    end
                end
                S_IP: begin
                    r_state <= (ip_dx == '0) ? S_STO : S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= S_STO;
                end
                S_STO: begin
                    r_ip    <= r_ip + 1'b1;
                    r_state <= (r_ip == 2'd2) ? S_OUT : S_IP;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_speed <= i_cmd.engine_speed;
            r_load  <= i_cmd.engine_load;
        end
        if ((r_state == S_CMP) && !scan_cont) begin
            if (r_axis) begin
                r_lb  <= LB_W'(r_bin);
                r_lx1 <= scan_d;
            end else begin
                r_sb  <= SB_W'(r_bin);
                r_sx1 <= scan_d;
            end
        end
        if (r_state == S_NXT) begin
            if (r_axis) begin
                r_ln  <= LB_W'(r_bin);
                r_lx2 <= scan_d;
            end else begin
                r_sn  <= SB_W'(r_bin);
                r_sx2 <= scan_d;
            end
        end
        if ((r_state == S_TRD) && (r_tcnt != 3'd0)) begin
            r_a[2'(r_tcnt - 1'b1)] <= r_tbl_q;
        end
        if (r_state == S_IP) begin
            r_y1  <= ip_y1;
            r_dxx <= ip_dxx;
            r_res <= ADV_W'(ip_y1);
        end
        if ((r_state == S_DIV) && div_rsp.done) begin
            r_quot <= div_rsp.quot;
        end
        if (r_state == S_MUL) begin
            r_prod <= mul;
        end
        if (r_state == S_ADD) begin
            r_res <= ADV_W'(r_y1) + ADV_W'(r_prod >>> aimi_pkg::FRAC_W);
        end
        if (r_state == S_STO) begin
            if (r_ip == 2'd0) begin
                r_r0 <= Y_W'(r_res);
            end
            if (r_ip == 2'd1) begin
                r_r1 <= Y_W'(r_res);
            end
        end
        if ((r_state == S_OUT) && !r_out_valid) begin
            r_out.advance_degrees <= sat;
            r_out.speed_bin       <= 4'(r_sb);
            r_out.load_bin        <= 4'(r_lb);
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ignition_advance_map_interpolator.sv
// Ignition advance map interpolator: a write item is applied as it leaves the
// queue; a lookup runs a bin search and table reads, then up to three
// interpolations whose slopes come from the bit-serial slope divider
// (NUM_W = 42). A synchronous active-low reset empties both queues.
`default_nettype none
module ignition_advance_map_interpolator #(
    parameter int SPEED_BINS = aimi_pkg::SPEED_BINS_DEF,
    parameter int LOAD_ROWS  = aimi_pkg::LOAD_ROWS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire aimi_pkg::t_in_item  i_in_item,
    output logic                     empty,
    input  wire logic                pop,
    output aimi_pkg::t_out_item      o_out_item
);
    logic               drop;
    logic               cmd_wr;
    logic               cmd_empty;
    logic               cmd_pop;
    aimi_pkg::t_in_item cmd;

    // Front end: writes with an index outside the table are discarded here.
    always_comb begin
        unique case (i_in_item.operation)
            aimi_pkg::OP_WR_SPEED: drop = (32'(i_in_item.row_index) >= SPEED_BINS);
            aimi_pkg::OP_WR_LOAD:  drop = (32'(i_in_item.row_index) >= LOAD_ROWS);
            aimi_pkg::OP_WR_CELL:  drop = (32'(i_in_item.row_index) >= LOAD_ROWS)
                                       || (32'(i_in_item.column_index) >= SPEED_BINS);
            default:               drop = 1'b0;
        endcase
        cmd_wr = push && !full && !drop;
    end

    aimi_cmd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_wr),
        .i_wr_item (i_in_item),
        .o_full    (full),
        .i_rd      (cmd_pop),
        .o_empty   (cmd_empty),
        .o_rd_item (cmd)
    );

    aimi_engine #(
        .SPEED_BINS (SPEED_BINS),
        .LOAD_ROWS  (LOAD_ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_empty (empty),
        .i_res_pop   (pop),
        .o_res       (o_out_item)
    );
endmodule
`default_nettype wire

>>> rtl/core/aimi_checker.sv
// Port-level checker for the ignition advance map interpolator, bound to the
// top level. Depends on aimi_pkg for the item types.
`default_nettype none
module aimi_checker #(
    parameter int SPEED_BINS = aimi_pkg::SPEED_BINS_DEF,
    parameter int LOAD_ROWS  = aimi_pkg::LOAD_ROWS_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire aimi_pkg::t_out_item o_out_item
);
    // Reset empties the result side.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // Reset empties the item queue.
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("queue full after reset");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed before it was taken");

    // Reported bins lie inside the table.
    a_bins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((32'(o_out_item.speed_bin) < SPEED_BINS || SPEED_BINS > 16)
                 && (32'(o_out_item.load_bin) < LOAD_ROWS || LOAD_ROWS > 16)))
        else $error("bin outside the table");
endmodule

bind ignition_advance_map_interpolator aimi_checker #(
    .SPEED_BINS (SPEED_BINS),
    .LOAD_ROWS  (LOAD_ROWS)
) u_aimi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
`default_nettype wire

>>> verif/ignition_advance_map_interpolator_tb.sv
// Self-checking testbench for the ignition advance map interpolator.
// Depends on aimi_pkg and ignition_advance_map_interpolator; predicts each lookup.
`timescale 1ns / 1ps
module ignition_advance_map_interpolator_tb;

    localparam int NBINS = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    aimi_pkg::t_in_item  i_in_item;
    logic                empty;
    logic                pop;
    aimi_pkg::t_out_item o_out_item;

    ignition_advance_map_interpolator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // Local copy of the tables, updated as items are accepted.
    logic [15:0]       speed_axis [NBINS];
    logic [15:0]       load_axis  [NBINS];
    logic signed [7:0] cell_map   [NBINS][NBINS];

    aimi_pkg::t_in_item  pending_items [$];
    aimi_pkg::t_out_item expected_lookups [$];
    int        fail_count = 0;
    int        burst_left;
    int        gap_left;
    int        stall_phase;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor of a signed value divided by 65536.
    function automatic longint floor16(longint v);
        if (v >= 0) return v >>> 16;
        return -(((-(v + 1))) >>> 16) - 1;
    endfunction

    function automatic longint lerp(longint x, longint x1, longint y1, longint x2, longint y2);
        longint slope;
        if (x2 == x1) return y1;
        slope = ((y2 - y1) * 65536) / (x2 - x1);
        return y1 + floor16(slope * (x - x1));
    endfunction

    // Scan downward from the top bin; next bin clamps at both ends.
    task automatic search_axis(input logic [15:0] axis [NBINS], input int x,
                               output int base, output int nxt);
        base = NBINS - 1;
        while (base > 0 && x < int'(axis[base])) base--;
        if (base == 0 && x < int'(axis[0])) nxt = 0;
        else nxt = (base < NBINS - 1) ? base + 1 : base;
    endtask

    task automatic apply_item(input aimi_pkg::t_in_item it);
        int sb, sn, lb, ln;
        longint r0, r1, adv;
        aimi_pkg::t_out_item res;
        case (it.operation)
            aimi_pkg::OP_WR_SPEED: speed_axis[it.row_index] = it.breakpoint_value;
            aimi_pkg::OP_WR_LOAD:  load_axis[it.row_index] = it.breakpoint_value;
            aimi_pkg::OP_WR_CELL:  cell_map[it.row_index][it.column_index] = it.cell_value;
            default: begin
                search_axis(speed_axis, int'(it.engine_speed), sb, sn);
                search_axis(load_axis, int'(it.engine_load), lb, ln);
                r0 = lerp(longint'(it.engine_speed), longint'(speed_axis[sb]),
                          longint'(cell_map[lb][sb]), longint'(speed_axis[sn]),
                          longint'(cell_map[lb][sn]));
                r1 = lerp(longint'(it.engine_speed), longint'(speed_axis[sb]),
                          longint'(cell_map[ln][sb]), longint'(speed_axis[sn]),
                          longint'(cell_map[ln][sn]));
                adv = lerp(longint'(it.engine_load), longint'(load_axis[lb]), r0,
                           longint'(load_axis[ln]), r1);
                if (adv > 127) adv = 127;
                if (adv < -128) adv = -128;
                res.advance_degrees = adv[7:0];
                res.speed_bin = sb[3:0];
                res.load_bin = lb[3:0];
                expected_lookups.push_back(res);
            end
        endcase
    endtask

    // Item builders for the stimulus queue.
    function automatic aimi_pkg::t_in_item rand_fields();
        aimi_pkg::t_in_item it;
        it.operation = aimi_pkg::OP_LOOKUP;
        it.engine_speed = 16'($urandom);
        it.engine_load = 16'($urandom);
        it.row_index = 4'($urandom);
        it.column_index = 4'($urandom);
        it.breakpoint_value = 16'($urandom);
        it.cell_value = 8'($urandom);
        return it;
    endfunction

    task automatic queue_write(input logic [1:0] op, input int r, input int c, input int v);
        aimi_pkg::t_in_item it;
        it = rand_fields();
        it.operation = op;
        it.row_index = 4'(r);
        it.column_index = 4'(c);
        it.breakpoint_value = 16'(v);
        it.cell_value = 8'(v);
        pending_items.push_back(it);
    endtask

    task automatic queue_lookup(input int s, input int l);
        aimi_pkg::t_in_item it;
        it = rand_fields();
        it.engine_speed = 16'(s);
        it.engine_load = 16'(l);
        pending_items.push_back(it);
    endtask

    // Fill every store so no lookup reads an unwritten entry.
    task automatic queue_full_map(input int sorted);
        int base, step;
        base = $urandom_range(0, 4000);
        step = $urandom_range(0, 4000);
        for (int i = 0; i < NBINS; i++) begin
            queue_write(aimi_pkg::OP_WR_SPEED, i, 0,
                        sorted ? base + i * step : $urandom_range(0, 65535));
            queue_write(aimi_pkg::OP_WR_LOAD, i, 0,
                        sorted ? 65535 - (15 - i) * step / 2 : $urandom_range(0, 65535));
        end
        for (int r = 0; r < NBINS; r++)
            for (int c = 0; c < NBINS; c++)
                queue_write(aimi_pkg::OP_WR_CELL, r, c, $urandom_range(0, 255));
    endtask

    // Driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_in_item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (push && !full) begin
                apply_item(i_in_item);
                void'(pending_items.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if (burst_left == 0 && !(push && full)) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                push <= 1'b0;
            end else begin
                if (push && !full) burst_left <= (burst_left > 0) ? burst_left - 1 : 0;
                // Present the next item, holding it while the block is full.
                if (pending_items.size() > 0) begin
                    push <= 1'b1;
                    i_in_item <= pending_items[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: pops with its own stall pattern and checks each lookup.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_lookups.size() == 0) begin
                    $error("unexpected lookup result %h", o_out_item);
                    fail_count++;
                end else begin
                    aimi_pkg::t_out_item exp_res;
                    exp_res = expected_lookups.pop_front();
                    if (o_out_item.advance_degrees !== exp_res.advance_degrees) begin
                        $error("advance_degrees expected %0d got %0d",
                               exp_res.advance_degrees, o_out_item.advance_degrees);
                        fail_count++;
                    end
                    if (o_out_item.speed_bin !== exp_res.speed_bin) begin
                        $error("speed_bin expected %0d got %0d",
                               exp_res.speed_bin, o_out_item.speed_bin);
                        fail_count++;
                    end
                    if (o_out_item.load_bin !== exp_res.load_bin) begin
                        $error("load_bin expected %0d got %0d",
                               exp_res.load_bin, o_out_item.load_bin);
                        fail_count++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 400;
            if (stall_phase < 150) pop <= 1'b1;
            else if (stall_phase < 250) pop <= ($urandom_range(0, 3) != 0);
            else pop <= ($urandom_range(0, 1) == 0);
        end
    end

    // Stimulus, then drain and verdict.
    initial begin
        int waited;
        bit lost;
        lost = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ordered map, extreme cells and one raised speed breakpoint, then corner lookups.
        queue_full_map(1);
        queue_write(aimi_pkg::OP_WR_CELL, 0, 0, 8'h7f);
        queue_write(aimi_pkg::OP_WR_CELL, 15, 15, 8'h80);
        queue_write(aimi_pkg::OP_WR_SPEED, 3, 0, 16'hffff);
        queue_lookup(0, 0);
        queue_lookup(65535, 65535);
        queue_lookup(0, 65535);
        queue_lookup(65535, 0);
        queue_lookup(32768, 40000);
        // Equal breakpoints: lower neighbours made identical.
        queue_write(aimi_pkg::OP_WR_SPEED, 5, 0, 1000);
        queue_write(aimi_pkg::OP_WR_SPEED, 6, 0, 1000);
        queue_lookup(1000, 50000);
        queue_lookup(1500, 60000);

        // Random: occasional fresh maps, some unordered, among many lookups and writes.
        while (pending_items.size() < 1300) begin
            if ($urandom_range(0, 3) == 0) queue_full_map($urandom_range(0, 2) != 0);
            repeat ($urandom_range(10, 40)) begin
                case ($urandom_range(0, 9))
                    0: queue_write(aimi_pkg::OP_WR_CELL, $urandom, $urandom, $urandom);
                    1: queue_write(2'($urandom_range(1, 2)), $urandom, 0, $urandom);
                    default: queue_lookup($urandom, $urandom);
                endcase
            end
        end

        wait (pending_items.size() == 0);
        waited = 0;
        while (expected_lookups.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_lookups.size() != 0) begin
            $error("%0d lookups never answered", expected_lookups.size());
            lost = 1'b1;
        end
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && !lost) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/aimi_pkg.sv
rtl/core/aimi_cmd_fifo.sv
rtl/core/aimi_divider.sv
rtl/core/aimi_engine.sv
rtl/core/ignition_advance_map_interpolator.sv
rtl/core/aimi_checker.sv
verif/ignition_advance_map_interpolator_tb.sv
